// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked, with a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check
`define THP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Next-cycle implication
`define THP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/thp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_pkg
// Shared types, constants and fixed-point helpers of the compensation core.
// ----------------------------------------------------------------------------
package thp_pkg;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);
   localparam int DIV_W  = 32;
   localparam int PRE_STAGES = 8;

   localparam logic signed [31:0] HUM_MAX = 32'sd419430400;

   typedef enum logic [2:0] {
      CSR_TEMP_CAL    = 3'd0,
      CSR_PRESS_CAL_A = 3'd1,
      CSR_PRESS_CAL_B = 3'd2,
      CSR_PRESS_CAL_C = 3'd3,
      CSR_HUM_CAL_A   = 3'd4,
      CSR_HUM_CAL_B   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [47:0] temp;
      logic [47:0] press_a;
      logic [47:0] press_b;
      logic [47:0] press_c;
      logic [31:0] hum_a;
      logic [31:0] hum_b;
   } cal_type;

   typedef struct packed {
      logic [31:0] tf;
      logic [19:0] raw_p;
      logic [15:0] raw_h;
   } q_item_type;

   typedef struct packed {
      logic [31:0] tc;
      logic [31:0] tf;
      logic [16:0] hum;
      logic        invalid;
      logic        dbl;
   } div_side_type;

   // signed divide by 2^k, truncating toward zero
   function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] v,
                                                  input int unsigned k);
      logic signed [31:0] bias;
      bias = v[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
      return (v + bias) >>> k;
   endfunction

   function automatic logic signed [31:0] sext16(input logic [15:0] v);
      return $signed({{16{v[15]}}, v});
   endfunction

   function automatic logic signed [31:0] sext12(input logic [11:0] v);
      return $signed({{20{v[11]}}, v});
   endfunction

   function automatic logic signed [31:0] sext8(input logic [7:0] v);
      return $signed({{24{v[7]}}, v});
   endfunction

endpackage

// ----- sv/thp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_req_if / thp_rsp_if
// Valid/ready channels for raw measurement sets and compensated results.
// ----------------------------------------------------------------------------
interface thp_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] raw_temperature;
   logic [19:0] raw_pressure;
   logic [15:0] raw_humidity;

   modport source (output valid, output raw_temperature, output raw_pressure,
                   output raw_humidity, input ready);
   modport sink (input valid, input raw_temperature, input raw_pressure,
                 input raw_humidity, output ready);
endinterface

interface thp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] temperature_centi;
   logic signed [31:0] fine_temperature;
   logic [31:0]        pressure_pa;
   logic               pressure_invalid;
   logic [16:0]        humidity_q10;

   modport source (output valid, output temperature_centi, output fine_temperature,
                   output pressure_pa, output pressure_invalid, output humidity_q10,
                   input ready);
   modport sink (input valid, input temperature_centi, input fine_temperature,
                 input pressure_pa, input pressure_invalid, input humidity_q10,
                 output ready);
endinterface

// ----- sv/thp_sensor_compensation_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_sensor_compensation_core
// Integer temperature, pressure and humidity compensation of one measurement
// set per transfer. The core accepts one set every clock cycle while its
// front end is not stalled and returns one result per set in order. A set
// passes the front end, the queue, the pre-divide stages, the pipelined
// pressure divider and the post-divide stages to the result register.
// The whole back end stalls together when the result is not taken; a
// 4-entry queue lets the front end keep accepting meanwhile. Calibration
// registers reset to zero and must be written while the core is idle.
// ----------------------------------------------------------------------------
module thp_sensor_compensation_core
   import thp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   thp_req_if.sink     req_ch,
   thp_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   logic [47:0] temp_cal_ff, press_cal_a_ff, press_cal_b_ff, press_cal_c_ff;
   logic [31:0] hum_cal_a_ff, hum_cal_b_ff;
   cal_type     cal;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff    <= '0;
         press_cal_a_ff <= '0;
         press_cal_b_ff <= '0;
         press_cal_c_ff <= '0;
         hum_cal_a_ff   <= '0;
         hum_cal_b_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TEMP_CAL:    temp_cal_ff    <= csr_wdata;
            CSR_PRESS_CAL_A: press_cal_a_ff <= csr_wdata;
            CSR_PRESS_CAL_B: press_cal_b_ff <= csr_wdata;
            CSR_PRESS_CAL_C: press_cal_c_ff <= csr_wdata;
            CSR_HUM_CAL_A:   hum_cal_a_ff   <= csr_wdata[31:0];
            CSR_HUM_CAL_B:   hum_cal_b_ff   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   assign cal.temp    = temp_cal_ff;
   assign cal.press_a = press_cal_a_ff;
   assign cal.press_b = press_cal_b_ff;
   assign cal.press_c = press_cal_c_ff;
   assign cal.hum_a   = hum_cal_a_ff;
   assign cal.hum_b   = hum_cal_b_ff;

   logic       fq_valid, fq_ready, qb_valid, qb_ready;
   q_item_type fq_item, qb_item;

   thp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cal       (cal),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .raw_t     (req_ch.raw_temperature),
      .raw_p     (req_ch.raw_pressure),
      .raw_h     (req_ch.raw_humidity),
      .out_valid (fq_valid),
      .out_ready (fq_ready),
      .out_item  (fq_item)
   );

   thp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_ready (fq_ready),
      .wr_item  (fq_item),
      .rd_valid (qb_valid),
      .rd_ready (qb_ready),
      .rd_item  (qb_item)
   );

   thp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cal         (cal),
      .in_valid    (qb_valid),
      .in_ready    (qb_ready),
      .in_item     (qb_item),
      .out_valid   (rsp_ch.valid),
      .out_ready   (rsp_ch.ready),
      .out_tc      (rsp_ch.temperature_centi),
      .out_tf      (rsp_ch.fine_temperature),
      .out_press   (rsp_ch.pressure_pa),
      .out_invalid (rsp_ch.pressure_invalid),
      .out_hum     (rsp_ch.humidity_q10)
   );

endmodule

// ----- sv/thp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_front
// Accepts measurement sets and derives the fine temperature in two stages.
// ----------------------------------------------------------------------------
module thp_front
   import thp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cal_type     cal,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [19:0] raw_t,
   input  logic [19:0] raw_p,
   input  logic [15:0] raw_h,
   output logic        out_valid,
   input  logic        out_ready,
   output q_item_type  out_item
);

   logic               f1_vld_ff, f2_vld_ff;
   logic signed [31:0] f1_m1_ff, f1_dd_ff;
   logic [19:0]        f1_rp_ff, f2_rp_ff;
   logic [15:0]        f1_rh_ff, f2_rh_ff;
   logic signed [31:0] f2_tf_ff;

   logic               fen;
   logic signed [31:0] t2s, t3s, diff_t, dlt, m1_in, dd_in, bm, tf_in;

   assign fen      = !f2_vld_ff || out_ready;
   assign in_ready = fen;

   always_comb begin
      t2s    = sext16(cal.temp[31:16]);
      t3s    = sext16(cal.temp[47:32]);
      diff_t = $signed({15'b0, raw_t[19:3]}) - $signed({15'b0, cal.temp[15:0], 1'b0});
      dlt    = $signed({16'b0, raw_t[19:4]}) - $signed({16'b0, cal.temp[15:0]});
      m1_in  = diff_t * t2s;
      dd_in  = dlt * dlt;
      bm     = (f1_dd_ff >>> 12) * t3s;
      tf_in  = (f1_m1_ff >>> 11) + (bm >>> 14);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
      end else if (fen) begin
         f1_vld_ff <= in_valid;
         f2_vld_ff <= f1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fen) begin
         f1_m1_ff <= m1_in;
         f1_dd_ff <= dd_in;
         f1_rp_ff <= raw_p;
         f1_rh_ff <= raw_h;
         f2_tf_ff <= tf_in;
         f2_rp_ff <= f1_rp_ff;
         f2_rh_ff <= f1_rh_ff;
      end
   end

   assign out_valid      = f2_vld_ff;
   assign out_item.tf    = f2_tf_ff;
   assign out_item.raw_p = f2_rp_ff;
   assign out_item.raw_h = f2_rh_ff;

endmodule

// ----- sv/thp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_queue
// Small FIFO between the temperature front end and the back end.
// ----------------------------------------------------------------------------
module thp_queue
   import thp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_valid,
   output logic       wr_ready,
   input  q_item_type wr_item,
   output logic       rd_valid,
   input  logic       rd_ready,
   output q_item_type rd_item
);

   q_item_type        mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              push, pop;

   assign wr_ready = (cnt_ff != QCNT_W'(QDEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign rd_item  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wr_item;
   end

endmodule

// ----- sv/thp_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_div
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module thp_div
   import thp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  logic [31:0]  num,
   input  logic [31:0]  den,
   input  div_side_type side_in,
   output logic         out_valid,
   output logic [31:0]  quo,
   output div_side_type side_out
);

   logic [DIV_W:0]  vld_ff;
   logic [31:0]     nq_ff   [DIV_W+1];
   logic [31:0]     rem_ff  [DIV_W];
   logic [31:0]     den_ff  [DIV_W];
   div_side_type    side_ff [DIV_W+1];

   logic [31:0]     nq_in   [DIV_W+1];
   logic [31:0]     rem_in  [DIV_W];
   logic [32:0]     trial, diff;
   logic            ge;

   always_comb begin
      trial = '0;
      diff  = '0;
      ge    = 1'b0;
      nq_in[0]  = '0;
      rem_in[0] = '0;
      for (int k = 0; k < DIV_W; k++) begin
         trial = {rem_ff[k], nq_ff[k][31]};
         diff  = trial - {1'b0, den_ff[k]};
         ge    = !diff[32];
         nq_in[k+1] = {nq_ff[k][30:0], ge};
         if (k < DIV_W - 1) begin
            rem_in[k+1] = ge ? diff[31:0] : trial[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DIV_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nq_ff[0]   <= num;
         rem_ff[0]  <= '0;
         den_ff[0]  <= den;
         side_ff[0] <= side_in;
         for (int k = 1; k <= DIV_W; k++) begin
            nq_ff[k]   <= nq_in[k];
            side_ff[k] <= side_ff[k-1];
            if (k < DIV_W) begin
               rem_ff[k] <= rem_in[k];
               den_ff[k] <= den_ff[k-1];
            end
         end
      end
   end

   assign out_valid = vld_ff[DIV_W];
   assign quo       = nq_ff[DIV_W];
   assign side_out  = side_ff[DIV_W];

endmodule

// ----- sv/thp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_back
// Pressure and humidity compensation pipeline with the divider and the
// result register. The whole back end advances as one when the result register
// is empty or its result is taken.
module thp_back
   import thp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cal_type            cal,
   input  logic               in_valid,
   output logic               in_ready,
   input  q_item_type         in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [31:0] out_tc,
   output logic signed [31:0] out_tf,
   output logic [31:0]        out_press,
   output logic               out_invalid,
   output logic [16:0]        out_hum
);

   logic en;

   // calibration words
   logic signed [31:0] p1s, p2s, p3s, p4s, p5s, p6s, p7s, p8s, p9s;
   logic signed [31:0] h1s, h2s, h3s, h4s, h5s, h6s;

   always_comb begin
      p1s = $signed({16'b0, cal.press_a[15:0]});
      p2s = sext16(cal.press_a[31:16]);
      p3s = sext16(cal.press_a[47:32]);
      p4s = sext16(cal.press_b[15:0]);
      p5s = sext16(cal.press_b[31:16]);
      p6s = sext16(cal.press_b[47:32]);
      p7s = sext16(cal.press_c[15:0]);
      p8s = sext16(cal.press_c[31:16]);
      p9s = sext16(cal.press_c[47:32]);
      h1s = $signed({24'b0, cal.hum_a[7:0]});
      h2s = sext16(cal.hum_a[23:8]);
      h3s = $signed({24'b0, cal.hum_a[31:24]});
      h4s = sext12(cal.hum_b[11:0]);
      h5s = sext12(cal.hum_b[23:12]);
      h6s = sext8(cal.hum_b[31:24]);
   end

   logic [PRE_STAGES:1] s_vld_ff;

   logic signed [31:0] s1_tc_ff, s1_tf_ff, s1_a0_ff, s1_hv_ff, s1_hx_ff;
   logic [19:0]        s1_rp_ff, s2_rp_ff, s3_rp_ff, s4_rp_ff;
   logic signed [31:0] s2_tc_ff, s2_tf_ff, s2_qq_ff, s2_mp5_ff, s2_mp2_ff;
   logic signed [31:0] s2_mh5_ff, s2_mh6_ff, s2_mh3_ff, s2_hx_ff;
   logic signed [31:0] s3_tc_ff, s3_tf_ff, s3_b1_ff, s3_x1_ff, s3_y_ff, s3_mp5_ff;
   logic signed [31:0] s3_hx_ff, s3_ha_ff, s3_hb_ff;
   logic signed [31:0] s4_tc_ff, s4_tf_ff, s4_b3_ff, s4_a1_ff, s4_hy1_ff, s4_hx_ff;
   logic signed [31:0] s5_tc_ff, s5_tf_ff, s5_a2_ff, s5_p0_ff, s5_hy2_ff, s5_hx_ff;
   logic signed [31:0] s6_tc_ff, s6_tf_ff, s6_a2_ff, s6_p0_ff, s6_hy_ff, s6_hx_ff;
   logic signed [31:0] s7_tc_ff, s7_tf_ff, s7_a2_ff, s7_p0_ff, s7_hv_ff;
   logic signed [31:0] s8_tc_ff, s8_tf_ff, s8_a2_ff, s8_p0_ff, s8_hv_ff, s8_sq_ff;

   logic signed [31:0] tf_q, tf5, q4, b2, t_p, hb_v, hvf, hvc;
   logic signed [31:0] ha8;

   logic signed [31:0] s1_tc_in, s1_a0_in, s1_hv_in, s1_hx_in;
   logic signed [31:0] s2_qq_in, s2_mp5_in, s2_mp2_in, s2_mh5_in, s2_mh6_in, s2_mh3_in;
   logic signed [31:0] s3_b1_in, s3_x1_in, s3_y_in, s3_hx_in, s3_ha_in, s3_hb_in;
   logic signed [31:0] s4_b3_in, s4_a1_in, s4_hy1_in;
   logic signed [31:0] s5_a2_in, s5_p0_in, s5_hy2_in;
   logic signed [31:0] s6_hy_in, s7_hv_in, s8_sq_in;

   logic [31:0]        div_num;
   div_side_type       div_side;

   always_comb begin
      tf_q     = $signed(in_item.tf);
      tf5      = (tf_q <<< 2) + tf_q;
      s1_tc_in = (tf5 + 32'sd128) >>> 8;
      s1_a0_in = sdiv_p2(tf_q, 1) - 32'sd64000;
      s1_hv_in = tf_q - 32'sd76800;
      s1_hx_in = $signed({2'b0, in_item.raw_h, 14'b0}) - (h4s <<< 20);

      q4        = sdiv_p2(s1_a0_ff, 2);
      s2_qq_in  = q4 * q4;
      s2_mp5_in = s1_a0_ff * p5s;
      s2_mp2_in = p2s * s1_a0_ff;
      s2_mh5_in = h5s * s1_hv_ff;
      s2_mh6_in = s1_hv_ff * h6s;
      s2_mh3_in = s1_hv_ff * h3s;

      s3_b1_in = sdiv_p2(s2_qq_ff, 11) * p6s;
      s3_x1_in = p3s * sdiv_p2(s2_qq_ff, 13);
      s3_y_in  = sdiv_p2(s2_mp2_ff, 1);
      s3_hx_in = (s2_hx_ff - s2_mh5_ff + 32'sd16384) >>> 15;
      s3_ha_in = s2_mh6_ff >>> 10;
      s3_hb_in = (s2_mh3_ff >>> 11) + 32'sd32768;

      b2        = s3_b1_ff + (s3_mp5_ff <<< 1);
      s4_b3_in  = sdiv_p2(b2, 2) + (p4s <<< 16);
      s4_a1_in  = sdiv_p2(sdiv_p2(s3_x1_ff, 3) + s3_y_ff, 18);
      s4_hy1_in = ((s3_ha_ff * s3_hb_ff) >>> 10) + 32'sd2097152;

      s5_a2_in  = sdiv_p2((32'sd32768 + s4_a1_ff) * p1s, 15);
      t_p       = $signed(32'd1048576 - {12'b0, s4_rp_ff}) - sdiv_p2(s4_b3_ff, 12);
      s5_p0_in  = t_p * 32'sd3125;
      s5_hy2_in = s4_hy1_ff * h2s;

      s6_hy_in = (s5_hy2_ff + 32'sd8192) >>> 14;
      s7_hv_in = s6_hx_ff * s6_hy_ff;
      ha8      = s7_hv_ff >>> 15;
      s8_sq_in = ha8 * ha8;

      hb_v = ((s8_sq_ff >>> 7) * h1s) >>> 4;
      hvf  = s8_hv_ff - hb_v;
      if (hvf < 32'sd0) begin
         hvc = 32'sd0;
      end else if (hvf > HUM_MAX) begin
         hvc = HUM_MAX;
      end else begin
         hvc = hvf;
      end

      div_num          = s8_p0_ff[31] ? s8_p0_ff : {s8_p0_ff[30:0], 1'b0};
      div_side.tc      = s8_tc_ff;
      div_side.tf      = s8_tf_ff;
      div_side.hum     = hvc[28:12];
      div_side.invalid = (s8_a2_ff == 32'sd0);
      div_side.dbl     = s8_p0_ff[31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= '0;
      end else if (en) begin
         s_vld_ff <= {s_vld_ff[PRE_STAGES-1:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_tc_ff  <= s1_tc_in;
         s1_tf_ff  <= tf_q;
         s1_a0_ff  <= s1_a0_in;
         s1_hv_ff  <= s1_hv_in;
         s1_hx_ff  <= s1_hx_in;
         s1_rp_ff  <= in_item.raw_p;

         s2_tc_ff  <= s1_tc_ff;
         s2_tf_ff  <= s1_tf_ff;
         s2_qq_ff  <= s2_qq_in;
         s2_mp5_ff <= s2_mp5_in;
         s2_mp2_ff <= s2_mp2_in;
         s2_mh5_ff <= s2_mh5_in;
         s2_mh6_ff <= s2_mh6_in;
         s2_mh3_ff <= s2_mh3_in;
         s2_hx_ff  <= s1_hx_ff;
         s2_rp_ff  <= s1_rp_ff;

         s3_tc_ff  <= s2_tc_ff;
         s3_tf_ff  <= s2_tf_ff;
         s3_b1_ff  <= s3_b1_in;
         s3_x1_ff  <= s3_x1_in;
         s3_y_ff   <= s3_y_in;
         s3_mp5_ff <= s2_mp5_ff;
         s3_hx_ff  <= s3_hx_in;
         s3_ha_ff  <= s3_ha_in;
         s3_hb_ff  <= s3_hb_in;
         s3_rp_ff  <= s2_rp_ff;

         s4_tc_ff  <= s3_tc_ff;
         s4_tf_ff  <= s3_tf_ff;
         s4_b3_ff  <= s4_b3_in;
         s4_a1_ff  <= s4_a1_in;
         s4_hy1_ff <= s4_hy1_in;
         s4_hx_ff  <= s3_hx_ff;
         s4_rp_ff  <= s3_rp_ff;

         s5_tc_ff  <= s4_tc_ff;
         s5_tf_ff  <= s4_tf_ff;
         s5_a2_ff  <= s5_a2_in;
         s5_p0_ff  <= s5_p0_in;
         s5_hy2_ff <= s5_hy2_in;
         s5_hx_ff  <= s4_hx_ff;

         s6_tc_ff  <= s5_tc_ff;
         s6_tf_ff  <= s5_tf_ff;
         s6_a2_ff  <= s5_a2_ff;
         s6_p0_ff  <= s5_p0_ff;
         s6_hy_ff  <= s6_hy_in;
         s6_hx_ff  <= s5_hx_ff;

         s7_tc_ff  <= s6_tc_ff;
         s7_tf_ff  <= s6_tf_ff;
         s7_a2_ff  <= s6_a2_ff;
         s7_p0_ff  <= s6_p0_ff;
         s7_hv_ff  <= s7_hv_in;

         s8_tc_ff  <= s7_tc_ff;
         s8_tf_ff  <= s7_tf_ff;
         s8_a2_ff  <= s7_a2_ff;
         s8_p0_ff  <= s7_p0_ff;
         s8_hv_ff  <= s7_hv_ff;
         s8_sq_ff  <= s8_sq_in;
      end
   end

   // divider
   logic         d_vld;
   logic [31:0]  d_quo;
   div_side_type d_side;

   thp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_vld_ff[PRE_STAGES]),
      .num       (div_num),
      .den       (s8_a2_ff),
      .side_in   (div_side),
      .out_valid (d_vld),
      .quo       (d_quo),
      .side_out  (d_side)
   );

   // post-divide correction
   logic               p1_vld_ff, p2_vld_ff, rsp_vld_ff;
   logic [31:0]        p1_p_ff, p1_pp_ff, p2_p_ff;
   logic signed [31:0] p1_m8_ff, p2_am_ff, p2_bq_ff;
   div_side_type       p1_side_ff, p2_side_ff;

   logic [31:0]        pq, p8th, pp_in, press_in;
   logic signed [31:0] m8_in, am_in, bq_in, xs;

   logic signed [31:0] rsp_tc_ff, rsp_tf_ff;
   logic [31:0]        rsp_press_ff;
   logic               rsp_invalid_ff;
   logic [16:0]        rsp_hum_ff;

   always_comb begin
      pq    = d_side.dbl ? {d_quo[30:0], 1'b0} : d_quo;
      p8th  = pq >> 3;
      pp_in = p8th * p8th;
      m8_in = $signed({2'b0, pq[31:2]}) * p8s;

      am_in = p9s * $signed({13'b0, p1_pp_ff[31:13]});
      bq_in = sdiv_p2(p1_m8_ff, 13);

      xs       = sdiv_p2(sdiv_p2(p2_am_ff, 12) + p2_bq_ff + p7s, 4);
      press_in = p2_side_ff.invalid ? 32'd0 : (p2_p_ff + $unsigned(xs));
   end

   assign en       = !rsp_vld_ff || out_ready;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         p1_vld_ff  <= d_vld;
         p2_vld_ff  <= p1_vld_ff;
         rsp_vld_ff <= p2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_p_ff        <= pq;
         p1_pp_ff       <= pp_in;
         p1_m8_ff       <= m8_in;
         p1_side_ff     <= d_side;
         p2_p_ff        <= p1_p_ff;
         p2_am_ff       <= am_in;
         p2_bq_ff       <= bq_in;
         p2_side_ff     <= p1_side_ff;
         rsp_tc_ff      <= $signed(p2_side_ff.tc);
         rsp_tf_ff      <= $signed(p2_side_ff.tf);
         rsp_press_ff   <= press_in;
         rsp_invalid_ff <= p2_side_ff.invalid;
         rsp_hum_ff     <= p2_side_ff.hum;
      end
   end

   assign out_valid   = rsp_vld_ff;
   assign out_tc      = rsp_tc_ff;
   assign out_tf      = rsp_tf_ff;
   assign out_press   = rsp_press_ff;
   assign out_invalid = rsp_invalid_ff;
   assign out_hum     = rsp_hum_ff;

endmodule

// ----- sv/thp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_checker
// Port-level checks on the result channel of the compensation core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module thp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] temperature_centi,
   input logic [31:0] fine_temperature,
   input logic [31:0] pressure_pa,
   input logic        pressure_invalid,
   input logic [16:0] humidity_q10
);

   `THP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   `THP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(pressure_pa) && $stable(humidity_q10) && $stable(fine_temperature), "result changed while stalled")
   `THP_ASSERT(a_invalid_zero, clock, reset, !(rsp_valid && pressure_invalid) || (pressure_pa == 32'd0), "invalid pressure not zero")
   `THP_ASSERT(a_hum_range, clock, reset, !rsp_valid || (humidity_q10 <= 17'd102400), "humidity above full scale")
   `THP_ASSERT(a_tc_from_tf, clock, reset, !rsp_valid || ($signed(temperature_centi) == (($signed(fine_temperature) * 32'sd5 + 32'sd128) >>> 8)), "temperature not derived from fine value")

endmodule

bind thp_sensor_compensation_core thp_checker u_thp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .temperature_centi (rsp_ch.temperature_centi),
   .fine_temperature  (rsp_ch.fine_temperature),
   .pressure_pa       (rsp_ch.pressure_pa),
   .pressure_invalid  (rsp_ch.pressure_invalid),
   .humidity_q10      (rsp_ch.humidity_q10)
);
